FILE: rtl/rpm_pkg.sv
package rpm_pkg;

  // Default grid bounds.
  localparam int unsigned DEF_MAX_ROWS = 32;
  localparam int unsigned DEF_MAX_COLS = 32;

  // Field widths fixed by the interface.
  localparam int unsigned CFG_W     = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CHOICE_W  = 16;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned WALL_W    = 7;
  localparam int unsigned LEFT_W    = 11;

  // Register reset values.
  localparam logic [CFG_W-1:0] RST_ROWS      = 6'd32;
  localparam logic [CFG_W-1:0] RST_COLS      = 6'd32;
  localparam logic [CFG_W-1:0] RST_START_ROW = 6'd1;
  localparam logic [CFG_W-1:0] RST_START_COL = 6'd1;

  // Frontier read-out tree group size.
  localparam int unsigned FR_GRP = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS      = 2'd0,
    CFG_COLS      = 2'd1,
    CFG_START_ROW = 2'd2,
    CFG_START_COL = 2'd3
  } cfg_idx_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_STARTED  = 2'd0,
    ST_CARVED   = 2'd1,
    ST_FINISHED = 2'd2
  } status_e;

  // Per-cell map state: bit 1 visited, bit 0 queued.
  localparam logic [1:0] CS_CLEAR   = 2'b00;
  localparam logic [1:0] CS_QUEUED  = 2'b01;
  localparam logic [1:0] CS_VISITED = 2'b10;
  localparam logic [1:0] CS_BOTH    = 2'b11;

  // Frontier chain commands.
  typedef struct packed {
    logic app;
    logic rem;
  } fr_ctl_t;

  // Clamp a one-based value to 1..hi and return it zero-based.
  function automatic int unsigned clamp_m1(input logic [CFG_W-1:0] v,
                                           input int unsigned hi);
    int unsigned x;
    x = int'(v);
    if (x == 0) return 0;
    if (x > hi) return hi - 1;
    return x - 1;
  endfunction

endpackage

FILE: rtl/rpm_if.sv
interface rpm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          op;
  logic [rpm_pkg::CHOICE_W-1:0]  choice;

  modport source (output valid, op, choice, input ready);
  modport sink (input valid, op, choice, output ready);
endinterface

interface rpm_out_if;
  logic                          valid;
  logic                          ready;
  logic [rpm_pkg::STATUS_W-1:0]  status;
  logic [rpm_pkg::WALL_W-1:0]    wall_row;
  logic [rpm_pkg::WALL_W-1:0]    wall_col;
  logic [rpm_pkg::LEFT_W-1:0]    frontier_left;

  modport source (output valid, status, wall_row, wall_col, frontier_left, input ready);
  modport sink (input valid, status, wall_row, wall_col, frontier_left, output ready);
endinterface

FILE: rtl/rpm_cell.sv
module rpm_cell #(
  parameter int unsigned ENT_W = 10,
  parameter int unsigned IDX_W = 10,
  parameter int unsigned CNT_W = 11,
  parameter int unsigned IDX   = 0
) (
  input  logic                 clk_i,
  input  rpm_pkg::fr_ctl_t     ctl_i,
  input  logic [ENT_W-1:0]     app_data_i,
  input  logic [CNT_W-1:0]     count_i,
  input  logic [IDX_W-1:0]     pick_i,
  input  logic [ENT_W-1:0]     next_i,
  output logic [ENT_W-1:0]     ent_o,
  output logic [ENT_W-1:0]     hit_o
);

  logic [ENT_W-1:0] ent_q;
  logic [ENT_W-1:0] hit_q;

  // Removal shifts the tail down by one; an append lands at the fill count.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rem && (IDX_W'(IDX) >= pick_i)) begin
      ent_q <= next_i;
    end else if (ctl_i.app && (CNT_W'(IDX) == count_i)) begin
      ent_q <= app_data_i;
    end
    // Only the picked cell offers its entry to the read-out tree.
    hit_q <= (IDX_W'(IDX) == pick_i) ? ent_q : '0;
  end

  assign ent_o = ent_q;
  assign hit_o = hit_q;

endmodule

FILE: rtl/rpm_frontier.sv
module rpm_frontier #(
  parameter int unsigned ENT_W = 10,
  parameter int unsigned IDX_W = 10,
  parameter int unsigned CNT_W = 11,
  parameter int unsigned CELLS = 1024
) (
  input  logic                 clk_i,
  input  rpm_pkg::fr_ctl_t     ctl_i,
  input  logic [ENT_W-1:0]     app_data_i,
  input  logic [CNT_W-1:0]     count_i,
  input  logic [IDX_W-1:0]     pick_i,
  output logic [ENT_W-1:0]     ent_o
);

  localparam int unsigned GRP  = rpm_pkg::FR_GRP;
  localparam int unsigned NGRP = (CELLS + GRP - 1) / GRP;

  logic [ENT_W-1:0] ent  [CELLS];
  logic [ENT_W-1:0] hit  [CELLS];
  logic [ENT_W-1:0] grp_d [NGRP];
  logic [ENT_W-1:0] grp_q [NGRP];

  // Row of frontier cells, each fed by its right-hand neighbor.
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic [ENT_W-1:0] nxt;
    if (i == CELLS - 1) begin : g_last
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = ent[i+1];
    end
    rpm_cell #(
      .ENT_W (ENT_W),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl_i),
      .app_data_i (app_data_i),
      .count_i    (count_i),
      .pick_i     (pick_i),
      .next_i     (nxt),
      .ent_o      (ent[i]),
      .hit_o      (hit[i])
    );
  end

  // First tree level: OR of each group of cells.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
      for (int m = 0; m < GRP; m++) begin
        if (g * GRP + m < CELLS) begin
          grp_d[g] = grp_d[g] | hit[g*GRP+m];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int g = 0; g < NGRP; g++) begin
      grp_q[g] <= grp_d[g];
    end
  end

  // Second level: OR of the group results.
  always_comb begin
    ent_o = '0;
    for (int g = 0; g < NGRP; g++) begin
      ent_o = ent_o | grp_q[g];
    end
  end

endmodule

FILE: rtl/rpm_map.sv
module rpm_map #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [1:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [1:0]    rdata_o
);

  logic [1:0] mem [DEPTH];
  logic [1:0] rdata_q;

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/random_prim_maze_carver.sv
// Start word: the result follows the map clearing pass, one cell per cycle, then the
// seed write and the scan of the start cell's neighbors. Step word: the result follows
// the frontier read-out tree and one map read and at most one map write per neighbor;
// a new word is taken only once the result has been loaded into the output register.
// A step on an empty frontier goes from the idle state straight to the response.
// Reset returns the registers to 32 by 32 with start at (1,1) and empties the
// frontier; the map is cleared by the clearing pass of each start word.
module random_prim_maze_carver #(
  parameter int unsigned MAX_ROWS = rpm_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = rpm_pkg::DEF_MAX_COLS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rpm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [rpm_pkg::CFG_W-1:0]     cfg_data_i,
  rpm_in_if.sink                        in_if,
  rpm_out_if.source                     out_if
);

  localparam int unsigned CELLS  = MAX_ROWS * MAX_COLS;
  localparam int unsigned ROW_W  = $clog2(MAX_ROWS);
  localparam int unsigned COL_W  = $clog2(MAX_COLS);
  localparam int unsigned ENT_W  = ROW_W + COL_W;
  localparam int unsigned IDX_W  = $clog2(CELLS);
  localparam int unsigned CNT_W  = $clog2(CELLS + 1);
  localparam int unsigned WALL_W = rpm_pkg::WALL_W;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_SEED, S_W1, S_W2, S_LOAD, S_NB, S_FIN, S_RESP
  } state_e;

  // Configuration registers.
  logic [rpm_pkg::CFG_W-1:0] rows_q, cols_q, srow_q, scol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= rpm_pkg::RST_ROWS;
      cols_q <= rpm_pkg::RST_COLS;
      srow_q <= rpm_pkg::RST_START_ROW;
      scol_q <= rpm_pkg::RST_START_COL;
    end else if (cfg_we_i) begin
      case (rpm_pkg::cfg_idx_e'(cfg_idx_i))
        rpm_pkg::CFG_ROWS:      rows_q <= cfg_data_i;
        rpm_pkg::CFG_COLS:      cols_q <= cfg_data_i;
        rpm_pkg::CFG_START_ROW: srow_q <= cfg_data_i;
        rpm_pkg::CFG_START_COL: scol_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e               state_q;
  logic [2:0]           nb_q;
  logic [IDX_W-1:0]     clr_q;
  logic [CNT_W-1:0]     count_q;
  logic [IDX_W-1:0]     pick_q;
  logic                 is_step_q;
  logic [ROW_W-1:0]     grmax_q;
  logic [COL_W-1:0]     gcmax_q;
  logic [ROW_W-1:0]     cur_r_q;
  logic [COL_W-1:0]     cur_c_q;
  logic [IDX_W-1:0]     nb_addr_q;
  logic                 nb_ok_q;
  logic [ENT_W-1:0]     nb_ent_q;
  logic                 wall_found_q;
  logic [WALL_W-1:0]    wall_r_q, wall_c_q;
  rpm_pkg::status_e     status_q;
  logic                 out_valid_q;
  rpm_pkg::status_e     out_status_q;
  logic [WALL_W-1:0]    out_wr_q, out_wc_q;
  logic [rpm_pkg::LEFT_W-1:0] out_left_q;

  logic                 in_acc;
  logic [ENT_W-1:0]     fr_ent;
  logic [1:0]           map_rd;
  logic                 map_we;
  logic [IDX_W-1:0]     map_waddr;
  logic [1:0]           map_wdata;
  rpm_pkg::fr_ctl_t     fr_ctl;

  logic [ROW_W-1:0]     seed_r;
  logic [COL_W-1:0]     seed_c;
  logic [ROW_W-1:0]     nb_r;
  logic [COL_W-1:0]     nb_c;
  logic                 nb_ok;
  logic [IDX_W-1:0]     nb_addr;
  logic [IDX_W-1:0]     cur_addr;
  logic                 chk;
  logic                 hit_wall;
  logic                 do_app;
  logic [1:0]           dr, dc;
  logic [WALL_W-1:0]    wall_r, wall_c;

  assign in_acc      = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == S_IDLE);

  // Clamped start cell within the latched grid.
  assign seed_r = ROW_W'(rpm_pkg::clamp_m1(srow_q, int'(grmax_q) + 1));
  assign seed_c = COL_W'(rpm_pkg::clamp_m1(scol_q, int'(gcmax_q) + 1));
  assign cur_addr = IDX_W'(int'(cur_r_q) * MAX_COLS + int'(cur_c_q));

  // Neighbor being read this cycle, in the order up, left, down, right.
  always_comb begin
    nb_r  = cur_r_q;
    nb_c  = cur_c_q;
    nb_ok = 1'b0;
    case (nb_q)
      3'd0: begin
        nb_r  = cur_r_q - ROW_W'(1);
        nb_ok = (cur_r_q != '0);
      end
      3'd1: begin
        nb_c  = cur_c_q - COL_W'(1);
        nb_ok = (cur_c_q != '0);
      end
      3'd2: begin
        nb_r  = cur_r_q + ROW_W'(1);
        nb_ok = (cur_r_q < grmax_q);
      end
      3'd3: begin
        nb_c  = cur_c_q + COL_W'(1);
        nb_ok = (cur_c_q < gcmax_q);
      end
      default: nb_ok = 1'b0;
    endcase
  end
  assign nb_addr = IDX_W'(int'(nb_r) * MAX_COLS + int'(nb_c));

  // Wall offsets in doubled coordinates for the neighbor checked this cycle.
  always_comb begin
    case (nb_q)
      3'd1:    begin dr = 2'd0; dc = 2'd1; end
      3'd2:    begin dr = 2'd1; dc = 2'd0; end
      3'd3:    begin dr = 2'd2; dc = 2'd1; end
      3'd4:    begin dr = 2'd1; dc = 2'd2; end
      default: begin dr = 2'd0; dc = 2'd0; end
    endcase
  end
  assign wall_r = WALL_W'(2 * int'(cur_r_q) + int'(dr));
  assign wall_c = WALL_W'(2 * int'(cur_c_q) + int'(dc));

  // Check of the neighbor whose map word arrived this cycle.
  assign chk      = (state_q == S_NB) && (nb_q != 3'd0) && nb_ok_q;
  assign hit_wall = chk && is_step_q && !wall_found_q && map_rd[1];
  assign do_app   = chk && !map_rd[1] && !map_rd[0] && (count_q < CNT_W'(CELLS));

  // Map write port.
  always_comb begin
    map_we    = 1'b0;
    map_waddr = nb_addr_q;
    map_wdata = rpm_pkg::CS_QUEUED;
    case (state_q)
      S_CLEAR: begin
        map_we    = 1'b1;
        map_waddr = clr_q;
        map_wdata = rpm_pkg::CS_CLEAR;
      end
      S_SEED: begin
        map_we    = 1'b1;
        map_waddr = IDX_W'(int'(seed_r) * MAX_COLS + int'(seed_c));
        map_wdata = rpm_pkg::CS_VISITED;
      end
      S_NB: map_we = do_app;
      S_FIN: begin
        map_we    = 1'b1;
        map_waddr = cur_addr;
        map_wdata = rpm_pkg::CS_BOTH;
      end
      default: map_we = 1'b0;
    endcase
  end

  assign fr_ctl.app = do_app;
  assign fr_ctl.rem = (state_q == S_FIN);

  rpm_map #(
    .DEPTH (CELLS),
    .AW    (IDX_W)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (nb_addr),
    .rdata_o (map_rd)
  );

  rpm_frontier #(
    .ENT_W (ENT_W),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W),
    .CELLS (CELLS)
  ) u_frontier (
    .clk_i      (clk_i),
    .ctl_i      (fr_ctl),
    .app_data_i (nb_ent_q),
    .count_i    (count_q),
    .pick_i     (pick_q),
    .ent_o      (fr_ent)
  );

  // Sequencer with its registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      nb_q         <= '0;
      clr_q        <= '0;
      count_q      <= '0;
      pick_q       <= '0;
      is_step_q    <= 1'b0;
      grmax_q      <= ROW_W'(rpm_pkg::clamp_m1(rpm_pkg::RST_ROWS, MAX_ROWS));
      gcmax_q      <= COL_W'(rpm_pkg::clamp_m1(rpm_pkg::RST_COLS, MAX_COLS));
      cur_r_q      <= '0;
      cur_c_q      <= '0;
      nb_addr_q    <= '0;
      nb_ok_q      <= 1'b0;
      nb_ent_q     <= '0;
      wall_found_q <= 1'b0;
      wall_r_q     <= '0;
      wall_c_q     <= '0;
      status_q     <= rpm_pkg::ST_STARTED;
      out_valid_q  <= 1'b0;
      out_status_q <= rpm_pkg::ST_STARTED;
      out_wr_q     <= '0;
      out_wc_q     <= '0;
      out_left_q   <= '0;
    end else begin
      // The response state reloads the word itself when it is taken there.
      if (out_if.valid && out_if.ready && (state_q != S_RESP)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            wall_found_q <= 1'b0;
            wall_r_q     <= '0;
            wall_c_q     <= '0;
            is_step_q    <= in_if.op;
            if (!in_if.op) begin
              grmax_q  <= ROW_W'(rpm_pkg::clamp_m1(rows_q, MAX_ROWS));
              gcmax_q  <= COL_W'(rpm_pkg::clamp_m1(cols_q, MAX_COLS));
              count_q  <= '0;
              clr_q    <= '0;
              status_q <= rpm_pkg::ST_STARTED;
              state_q  <= S_CLEAR;
            end else if (count_q == '0) begin
              status_q <= rpm_pkg::ST_FINISHED;
              state_q  <= S_RESP;
            end else begin
              pick_q   <= IDX_W'((CNT_W + rpm_pkg::CHOICE_W)'(in_if.choice * count_q)
                                 >> rpm_pkg::CHOICE_W);
              status_q <= rpm_pkg::ST_CARVED;
              state_q  <= S_W1;
            end
          end
        end
        S_CLEAR: begin
          clr_q <= clr_q + IDX_W'(1);
          if (clr_q == IDX_W'(CELLS - 1)) begin
            state_q <= S_SEED;
          end
        end
        S_SEED: begin
          cur_r_q <= seed_r;
          cur_c_q <= seed_c;
          nb_q    <= '0;
          state_q <= S_NB;
        end
        S_W1: state_q <= S_W2;
        S_W2: state_q <= S_LOAD;
        S_LOAD: begin
          cur_r_q <= fr_ent[ENT_W-1:COL_W];
          cur_c_q <= fr_ent[COL_W-1:0];
          nb_q    <= '0;
          state_q <= S_NB;
        end
        S_NB: begin
          nb_addr_q <= nb_addr;
          nb_ok_q   <= nb_ok;
          nb_ent_q  <= {nb_r, nb_c};
          if (hit_wall) begin
            wall_found_q <= 1'b1;
            wall_r_q     <= wall_r;
            wall_c_q     <= wall_c;
          end
          if (do_app) begin
            count_q <= count_q + CNT_W'(1);
          end
          nb_q <= nb_q + 3'd1;
          if (nb_q == 3'd4) begin
            state_q <= is_step_q ? S_FIN : S_RESP;
          end
        end
        S_FIN: begin
          count_q <= count_q - CNT_W'(1);
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || out_if.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= status_q;
            out_wr_q     <= wall_r_q;
            out_wc_q     <= wall_c_q;
            out_left_q   <= rpm_pkg::LEFT_W'(count_q);
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.status        = out_status_q;
  assign out_if.wall_row      = out_wr_q;
  assign out_if.wall_col      = out_wc_q;
  assign out_if.frontier_left = out_left_q;

  // The frontier never holds more entries than the grid has cells.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CELLS))
    else $error("frontier count beyond grid size");

  // Removing the carved entry shortens the frontier by exactly one.
  a_remove_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("frontier removal did not shorten the list by one");

  // A new word appears only from the response state.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == S_RESP))
    else $error("result word raised outside the response state");

  // A finished word reports an empty frontier and no wall.
  a_finished_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == rpm_pkg::ST_FINISHED)) |->
      (out_left_q == '0 && out_wr_q == '0 && out_wc_q == '0))
    else $error("finished word carries nonzero fields");

  // A started word carries no wall.
  a_started_nowall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_status_q == rpm_pkg::ST_STARTED)) |->
      (out_wr_q == '0 && out_wc_q == '0))
    else $error("started word carries a wall");

endmodule

FILE: tb/sv/rpm_maze_checker.sv
module rpm_maze_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [5:0]  cfg_data_i,
  rpm_in_if.sink      in_mon,
  rpm_out_if.sink     out_mon,
  output int          fail_count,
  output int          pending_count,
  output int          carve_count,
  output int          finish_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NROW = 32;
  localparam int NCOL = 32;
  localparam int NCELL = NROW * NCOL;

  typedef struct packed {
    rpm_pkg::status_e status;
    logic [6:0]       wall_row;
    logic [6:0]       wall_col;
    logic [10:0]      left;
  } maze_word_t;

  // Shadow copy of the registers and the maze state.
  logic [5:0] reg_rows, reg_cols, reg_srow, reg_scol;
  int         grid_rows, grid_cols;
  bit         visited[NCELL];
  bit         queued[NCELL];
  int         frontier[$];
  maze_word_t expected_words[$];

  function automatic int clamp_to(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic bit is_visited(int r, int c);
    return visited[(r - 1) * NCOL + (c - 1)];
  endfunction

  // Append a cell to the frontier unless it is visited or already queued.
  task automatic add_cell(int r, int c);
    int k;
    k = (r - 1) * NCOL + (c - 1);
    if (visited[k] || queued[k]) return;
    frontier.insert(frontier.size(), k);
    queued[k] = 1'b1;
  endtask

  task automatic add_neighbors(int r, int c);
    if (r > 1) add_cell(r - 1, c);
    if (c > 1) add_cell(r, c - 1);
    if (r < grid_rows) add_cell(r + 1, c);
    if (c < grid_cols) add_cell(r, c + 1);
  endtask

  // Predict the result word of one accepted input word.
  task automatic predict_carve(logic op, logic [15:0] choice);
    maze_word_t w;
    int pick, k, r, c, sr, sc;
    w = '0;
    if (op == 1'b0) begin
      foreach (visited[i]) begin
        visited[i] = 1'b0;
        queued[i] = 1'b0;
      end
      frontier.delete();
      grid_rows = clamp_to(reg_rows, NROW);
      grid_cols = clamp_to(reg_cols, NCOL);
      sr = clamp_to(reg_srow, grid_rows);
      sc = clamp_to(reg_scol, grid_cols);
      visited[(sr - 1) * NCOL + (sc - 1)] = 1'b1;
      add_neighbors(sr, sc);
      w.status = rpm_pkg::ST_STARTED;
    end else if (frontier.size() == 0) begin
      w.status = rpm_pkg::ST_FINISHED;
    end else begin
      pick = int'((longint'(choice) * frontier.size()) >> 16);
      k = frontier[pick];
      r = k / NCOL + 1;
      c = k % NCOL + 1;
      if (r > 1 && is_visited(r - 1, c)) begin
        w.wall_row = 7'(2 * r - 2); w.wall_col = 7'(2 * c - 1);
      end else if (c > 1 && is_visited(r, c - 1)) begin
        w.wall_row = 7'(2 * r - 1); w.wall_col = 7'(2 * c - 2);
      end else if (r < grid_rows && is_visited(r + 1, c)) begin
        w.wall_row = 7'(2 * r); w.wall_col = 7'(2 * c - 1);
      end else if (c < grid_cols && is_visited(r, c + 1)) begin
        w.wall_row = 7'(2 * r - 1); w.wall_col = 7'(2 * c);
      end
      visited[k] = 1'b1;
      add_neighbors(r, c);
      frontier.delete(pick);
      w.status = rpm_pkg::ST_CARVED;
    end
    w.left = 11'(frontier.size());
    expected_words.insert(expected_words.size(), w);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  // Track registers, predict on input words and compare output words.
  always @(posedge clk_i or negedge rst_ni) begin
    maze_word_t e;
    if (!rst_ni) begin
      reg_rows <= rpm_pkg::RST_ROWS;
      reg_cols <= rpm_pkg::RST_COLS;
      reg_srow <= rpm_pkg::RST_START_ROW;
      reg_scol <= rpm_pkg::RST_START_COL;
      grid_rows = NROW;
      grid_cols = NCOL;
      frontier.delete();
      expected_words.delete();
      pending_count = 0;
      fail_count = 0;
      carve_count = 0;
      finish_count = 0;
    end else begin
      if (cfg_we_i) begin
        case (rpm_pkg::cfg_idx_e'(cfg_idx_i))
          rpm_pkg::CFG_ROWS:      reg_rows <= cfg_data_i;
          rpm_pkg::CFG_COLS:      reg_cols <= cfg_data_i;
          rpm_pkg::CFG_START_ROW: reg_srow <= cfg_data_i;
          rpm_pkg::CFG_START_COL: reg_scol <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) predict_carve(in_mon.op, in_mon.choice);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected output word", 1, 0);
        end else begin
          e = expected_words.pop_front();
          if (out_mon.status != e.status) report_mismatch("status", out_mon.status, e.status);
          if (out_mon.wall_row != e.wall_row)
            report_mismatch("wall_row", out_mon.wall_row, e.wall_row);
          if (out_mon.wall_col != e.wall_col)
            report_mismatch("wall_col", out_mon.wall_col, e.wall_col);
          if (out_mon.frontier_left != e.left)
            report_mismatch("frontier_left", out_mon.frontier_left, e.left);
          if (e.status == rpm_pkg::ST_CARVED) carve_count++;
          if (e.status == rpm_pkg::ST_FINISHED) finish_count++;
        end
      end
      pending_count = expected_words.size();
    end
  end
endmodule

FILE: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 20000;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [5:0] cfg_data_i;
  int         fail_count, pending_count, carve_count, finish_count;
  int         sent_words, quiet_cycles, maze_count;
  bit         calm_phase;

  rpm_in_if  in_ch ();
  rpm_out_if out_ch ();

  random_prim_maze_carver dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  rpm_maze_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .fail_count, .pending_count, .carve_count, .finish_count
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog on cycles where no word moves on either channel.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result side stalls in random bursts until the calm phase.
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!calm_phase && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        n = $urandom_range(1, 13);
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Send one input word and wait for its acceptance; valid is dropped by
  // the next idle burst or by the drain.
  task automatic send_word(logic op, logic [15:0] choice);
    int n;
    if (!calm_phase && $urandom_range(0, 6) == 0) begin
      in_ch.valid <= 1'b0;
      n = $urandom_range(1, 13);
      repeat (n) @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.choice <= choice;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
    sent_words++;
  endtask

  // Write enable is dropped by the caller after the last write.
  task automatic write_reg(rpm_pkg::cfg_idx_e idx, logic [5:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
  endtask

  // Let every expected word drain before touching the registers.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
  endtask

  task automatic set_grid(int r, int c, int sr, int sc);
    drain_results();
    write_reg(rpm_pkg::CFG_ROWS, 6'(r));
    write_reg(rpm_pkg::CFG_COLS, 6'(c));
    write_reg(rpm_pkg::CFG_START_ROW, 6'(sr));
    write_reg(rpm_pkg::CFG_START_COL, 6'(sc));
    cfg_we_i <= 1'b0;
  endtask

  // One maze: a start, then the given number of steps; steps after the frontier is spent finish.
  task automatic carve_maze(int steps);
    send_word(1'b0, 16'($urandom));
    maze_count++;
    repeat (steps) send_word(1'b1, 16'($urandom));
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = 1'b0;
    in_ch.choice = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = rpm_pkg::CFG_ROWS;
    cfg_data_i = '0;
    calm_phase = 1'b0;
    sent_words = 0;
    maze_count = 0;
    rst_ni = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: step before any start, then a full-size maze with extreme choices.
    send_word(1'b1, 16'hffff);
    send_word(1'b0, 16'h0000);
    send_word(1'b1, 16'h0000);
    send_word(1'b1, 16'hffff);
    send_word(1'b1, 16'h5555);
    send_word(1'b1, 16'haaaa);
    // Single cell: start yields an empty frontier, steps finish at once.
    set_grid(1, 1, 1, 1);
    carve_maze(2);
    // Zero sizes clamp up, oversize start clamps down.
    set_grid(0, 0, 0, 0);
    carve_maze(1);
    set_grid(2, 3, 63, 63);
    carve_maze(7);
    set_grid(63, 63, 40, 40);
    carve_maze(4);
    // Hold the sender until everything has come back.
    drain_results();

    // Random mazes, mostly small, with a few at full size.
    while (sent_words < 960) begin
      if ($urandom_range(0, 9) == 0) set_grid(32, 32, $urandom_range(0, 63), $urandom_range(0, 63));
      else set_grid($urandom_range(0, 8), $urandom_range(0, 8),
                    $urandom_range(0, 9), $urandom_range(0, 9));
      if (sent_words > 880) calm_phase = 1'b1;
      if ($urandom_range(0, 7) == 0) send_word(1'b1, 16'($urandom));
      carve_maze($urandom_range(0, 70));
    end
    calm_phase = 1'b1;
    carve_maze(50);

    drain_results();
    $display("Carved %0d mazes from %0d input words: %0d walls opened, %0d finished steps.",
             maze_count, sent_words, carve_count, finish_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
